// ===== rtl/pts_pkg.sv =====
// Shared types and codes for the periodic task scheduler.
package pts_pkg;

    // Transaction actions
    localparam logic [2:0] ACT_TICK    = 3'd0;
    localparam logic [2:0] ACT_ADD     = 3'd1;
    localparam logic [2:0] ACT_REMOVE  = 3'd2;
    localparam logic [2:0] ACT_SUSPEND = 3'd3;
    localparam logic [2:0] ACT_RESUME  = 3'd4;

    // Task states
    localparam logic [1:0] TS_READY     = 2'd0;
    localparam logic [1:0] TS_RUNNING   = 2'd1;
    localparam logic [1:0] TS_WAITING   = 2'd2;
    localparam logic [1:0] TS_SUSPENDED = 2'd3;

    // Result status codes
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_IDLE      = 2'd1;
    localparam logic [1:0] STAT_FULL      = 2'd2;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd3;

    // Configuration register indexes
    localparam logic CFG_TICK_INTERVAL = 1'b0;
    localparam logic CFG_POLICY_MODE   = 1'b1;

    // One task table entry as held in the entry memory
    typedef struct packed {
        logic [7:0]  prio;
        logic [31:0] id;
        logic [15:0] period;
        logic [31:0] release_time;
        logic [31:0] runs;
    } entry_t;

    // Evaluation of one slot during a scan
    typedef struct packed {
        logic        release_due;
        logic        ready;
        logic [31:0] new_release;
        logic        id_match;
        logic        susp_match;
    } slot_eval_t;

endpackage

// ===== rtl/periodic_task_scheduler.sv =====
// Periodic task scheduler top level: sequencer, entry memory and result register.
// Tick, remove, suspend and resume scan the table one slot per cycle through one read port.
// Those four go through scan and post, a tick that runs a task then pick write; add and
// unknown actions go straight to post. The result loads in the last step, which a stalled
// result holds. The next transaction enters the cycle after its result loads. Reset clears
// valid, flags and time; next id goes to 1, last pick to the last slot, config to defaults.
module periodic_task_scheduler #(
    parameter int TABLE_SLOTS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  action,
    input  logic [7:0]  task_priority,
    input  logic [15:0] task_period,
    input  logic [31:0] target_id,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [31:0] result_id,
    output logic [3:0]  result_slot,
    output logic [31:0] tick_time,
    output logic [31:0] run_total,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int CNT_W = IDX_W + 1;
    localparam logic [CNT_W-1:0] CNT_END = CNT_W'(TABLE_SLOTS);
    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(TABLE_SLOTS - 1);

    localparam logic [1:0] S_IDLE    = 2'd0;
    localparam logic [1:0] S_SCAN    = 2'd1;
    localparam logic [1:0] S_POST    = 2'd2;
    localparam logic [1:0] S_PICK_WR = 2'd3;

    // Control and configuration
    logic [1:0]       state_reg;
    logic [15:0]      interval_reg;
    logic             policy_reg;
    logic [31:0]      time_reg;
    logic [31:0]      next_id_reg;
    logic [IDX_W-1:0] last_pick_reg;
    logic [CNT_W-1:0] cnt_reg;

    // Latched transaction
    logic [2:0]  act_reg;
    logic [7:0]  prio_reg;
    logic [15:0] period_reg;
    logic [31:0] target_reg;

    // Table flags and entry memory
    logic [TABLE_SLOTS-1:0] active_reg;
    logic [1:0]             tstate_reg [TABLE_SLOTS];
    pts_pkg::entry_t        mem [TABLE_SLOTS];
    pts_pkg::entry_t        rdata_reg;
    logic [IDX_W-1:0]       rd_addr;
    logic                   proc_vld_reg;
    logic [IDX_W-1:0]       proc_idx_reg;

    // Scan trackers
    logic             best_vld_reg;
    logic [7:0]       best_prio_reg;
    logic [31:0]      best_id_reg;
    logic [IDX_W-1:0] best_slot_reg;
    logic             rr_hi_vld_reg;
    logic [IDX_W-1:0] rr_hi_slot_reg;
    logic             rr_lo_vld_reg;
    logic [IDX_W-1:0] rr_lo_slot_reg;
    logic             m_vld_reg;
    logic [IDX_W-1:0] m_slot_reg;
    logic             r_vld_reg;
    logic [IDX_W-1:0] r_slot_reg;

    // Result register
    logic        out_valid_reg;
    logic [1:0]  status_reg;
    logic [31:0] result_id_reg;
    logic [3:0]  result_slot_reg;
    logic [31:0] tick_time_reg;
    logic [31:0] run_total_reg;

    // Combinational helpers
    pts_pkg::slot_eval_t ev;
    logic             in_acc;
    logic             out_free;
    logic             pick_vld;
    logic [IDX_W-1:0] pick_slot;
    logic             free_vld;
    logic [IDX_W-1:0] free_slot;
    logic             finish;
    logic [1:0]       ld_status;
    logic [31:0]      ld_id;
    logic [IDX_W-1:0] ld_slot;
    logic [IDX_W+3:0] ld_slot_ext;
    logic [31:0]      ld_time;
    logic [31:0]      ld_runs;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    pts_pkg::entry_t  mem_wdata;

    assign in_stall    = (state_reg != S_IDLE);
    assign in_acc      = in_valid && !in_stall;
    assign out_free    = !out_valid_reg || !out_stall;
    assign cfg_ready   = 1'b1;
    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign result_id   = result_id_reg;
    assign result_slot = result_slot_reg;
    assign tick_time   = tick_time_reg;
    assign run_total   = run_total_reg;
    assign ld_slot_ext = {4'd0, ld_slot};

    // Evaluate the slot whose entry was just read
    pts_slot_eval u_eval
    (
        .entry    (rdata_reg),
        .active   (active_reg[proc_idx_reg]),
        .state    (tstate_reg[proc_idx_reg]),
        .cur_time (time_reg),
        .target   (target_reg),
        .ev       (ev)
    );

    // Select the picked slot from the scan trackers
    always_comb
    begin
        if (policy_reg)
        begin
            pick_vld  = best_vld_reg;
            pick_slot = best_slot_reg;
        end
        else
        begin
            pick_vld  = rr_hi_vld_reg || rr_lo_vld_reg;
            pick_slot = rr_hi_vld_reg ? rr_hi_slot_reg : rr_lo_slot_reg;
        end
    end

    // Find the lowest free slot
    always_comb
    begin
        free_vld  = 1'b0;
        free_slot = '0;
        for (int i = TABLE_SLOTS - 1; i >= 0; i--)
        begin
            if (!active_reg[i])
            begin
                free_vld  = 1'b1;
                free_slot = IDX_W'(i);
            end
        end
    end

    // Read address: scan counter while scanning, else the picked slot
    assign rd_addr = (state_reg == S_SCAN) ? cnt_reg[IDX_W-1:0] : pick_slot;

    // Decide memory writes and result loads
    always_comb
    begin
        finish    = 1'b0;
        ld_status = pts_pkg::STAT_OK;
        ld_id     = '0;
        ld_slot   = '0;
        ld_time   = '0;
        ld_runs   = '0;
        mem_we    = 1'b0;
        mem_waddr = proc_idx_reg;
        mem_wdata = rdata_reg;
        unique case (state_reg)
            S_SCAN:
            begin
                if (proc_vld_reg && (act_reg == pts_pkg::ACT_TICK) && ev.release_due)
                begin
                    mem_we                 = 1'b1;
                    mem_wdata.release_time = ev.new_release;
                end
            end
            S_POST:
            begin
                if (!((act_reg == pts_pkg::ACT_TICK) && pick_vld) && out_free)
                begin
                    finish = 1'b1;
                    case (act_reg)
                        pts_pkg::ACT_TICK:
                        begin
                            ld_status = pts_pkg::STAT_IDLE;
                            ld_time   = time_reg;
                        end
                        pts_pkg::ACT_ADD:
                        begin
                            if (free_vld)
                            begin
                                ld_id     = next_id_reg;
                                ld_slot   = free_slot;
                                mem_we    = 1'b1;
                                mem_waddr = free_slot;
                                mem_wdata = '{prio: prio_reg, id: next_id_reg,
                                              period: period_reg,
                                              release_time: 32'd0, runs: 32'd0};
                            end
                            else
                            begin
                                ld_status = pts_pkg::STAT_FULL;
                            end
                        end
                        pts_pkg::ACT_REMOVE, pts_pkg::ACT_SUSPEND:
                        begin
                            if (!m_vld_reg)
                            begin
                                ld_status = pts_pkg::STAT_NOT_FOUND;
                            end
                        end
                        pts_pkg::ACT_RESUME:
                        begin
                            if (!r_vld_reg)
                            begin
                                ld_status = pts_pkg::STAT_NOT_FOUND;
                            end
                        end
                        default:
                        begin
                            ld_status = pts_pkg::STAT_OK;
                        end
                    endcase
                end
            end
            S_PICK_WR:
            begin
                if (out_free)
                begin
                    finish         = 1'b1;
                    ld_id          = rdata_reg.id;
                    ld_slot        = pick_slot;
                    ld_time        = time_reg;
                    ld_runs        = rdata_reg.runs + 32'd1;
                    mem_we         = 1'b1;
                    mem_waddr      = pick_slot;
                    mem_wdata.runs = rdata_reg.runs + 32'd1;
                end
            end
            default:
            begin
                finish = 1'b0;
            end
        endcase
    end

    // Entry memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[rd_addr];
    end

    // Take configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg <= 16'd10;
            policy_reg   <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                pts_pkg::CFG_TICK_INTERVAL: interval_reg <= cfg_data;
                pts_pkg::CFG_POLICY_MODE:   policy_reg   <= cfg_data[0];
                default:                    interval_reg <= interval_reg;
            endcase
        end
    end

    // Hold the accepted transaction fields
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            act_reg    <= action;
            prio_reg   <= task_priority;
            period_reg <= task_period;
            target_reg <= target_id;
        end
        proc_idx_reg <= cnt_reg[IDX_W-1:0];
    end

    // Sequencer, table flags and scan trackers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            proc_vld_reg   <= 1'b0;
            time_reg       <= '0;
            next_id_reg    <= 32'd1;
            last_pick_reg  <= LAST_SLOT;
            active_reg     <= '0;
            best_vld_reg   <= 1'b0;
            best_prio_reg  <= '0;
            best_id_reg    <= '0;
            best_slot_reg  <= '0;
            rr_hi_vld_reg  <= 1'b0;
            rr_hi_slot_reg <= '0;
            rr_lo_vld_reg  <= 1'b0;
            rr_lo_slot_reg <= '0;
            m_vld_reg      <= 1'b0;
            m_slot_reg     <= '0;
            r_vld_reg      <= 1'b0;
            r_slot_reg     <= '0;
            for (int i = 0; i < TABLE_SLOTS; i++)
            begin
                tstate_reg[i] <= pts_pkg::TS_READY;
            end
        end
        else
        begin
            proc_vld_reg <= (state_reg == S_SCAN) && (cnt_reg != CNT_END);
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        cnt_reg       <= '0;
                        best_vld_reg  <= 1'b0;
                        rr_hi_vld_reg <= 1'b0;
                        rr_lo_vld_reg <= 1'b0;
                        m_vld_reg     <= 1'b0;
                        r_vld_reg     <= 1'b0;
                        if ((action == pts_pkg::ACT_TICK) || (action == pts_pkg::ACT_REMOVE)
                            || (action == pts_pkg::ACT_SUSPEND)
                            || (action == pts_pkg::ACT_RESUME))
                        begin
                            state_reg <= S_SCAN;
                        end
                        else
                        begin
                            state_reg <= S_POST;
                        end
                    end
                end
                S_SCAN:
                begin
                    // Advance the read counter; drop to post once all slots issued
                    if (cnt_reg != CNT_END)
                    begin
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end
                    else
                    begin
                        state_reg <= S_POST;
                    end
                    if (proc_vld_reg)
                    begin
                        if (act_reg == pts_pkg::ACT_TICK)
                        begin
                            if (ev.release_due)
                            begin
                                tstate_reg[proc_idx_reg] <= pts_pkg::TS_READY;
                            end
                            if (ev.ready)
                            begin
                                if (!best_vld_reg
                                    || ({rdata_reg.prio, rdata_reg.id}
                                        < {best_prio_reg, best_id_reg}))
                                begin
                                    best_vld_reg  <= 1'b1;
                                    best_prio_reg <= rdata_reg.prio;
                                    best_id_reg   <= rdata_reg.id;
                                    best_slot_reg <= proc_idx_reg;
                                end
                                if (!rr_hi_vld_reg && (proc_idx_reg > last_pick_reg))
                                begin
                                    rr_hi_vld_reg  <= 1'b1;
                                    rr_hi_slot_reg <= proc_idx_reg;
                                end
                                if (!rr_lo_vld_reg)
                                begin
                                    rr_lo_vld_reg  <= 1'b1;
                                    rr_lo_slot_reg <= proc_idx_reg;
                                end
                            end
                        end
                        if (ev.id_match && !m_vld_reg)
                        begin
                            m_vld_reg  <= 1'b1;
                            m_slot_reg <= proc_idx_reg;
                        end
                        if (ev.susp_match && !r_vld_reg)
                        begin
                            r_vld_reg  <= 1'b1;
                            r_slot_reg <= proc_idx_reg;
                        end
                    end
                end
                S_POST:
                begin
                    if ((act_reg == pts_pkg::ACT_TICK) && pick_vld)
                    begin
                        state_reg <= S_PICK_WR;
                    end
                    else if (finish)
                    begin
                        state_reg <= S_IDLE;
                        case (act_reg)
                            pts_pkg::ACT_TICK:
                            begin
                                time_reg <= time_reg + {16'd0, interval_reg};
                            end
                            pts_pkg::ACT_ADD:
                            begin
                                if (free_vld)
                                begin
                                    active_reg[free_slot] <= 1'b1;
                                    tstate_reg[free_slot] <= pts_pkg::TS_READY;
                                    next_id_reg           <= next_id_reg + 32'd1;
                                end
                            end
                            pts_pkg::ACT_REMOVE:
                            begin
                                if (m_vld_reg)
                                begin
                                    active_reg[m_slot_reg] <= 1'b0;
                                end
                            end
                            pts_pkg::ACT_SUSPEND:
                            begin
                                if (m_vld_reg)
                                begin
                                    tstate_reg[m_slot_reg] <= pts_pkg::TS_SUSPENDED;
                                end
                            end
                            pts_pkg::ACT_RESUME:
                            begin
                                if (r_vld_reg)
                                begin
                                    tstate_reg[r_slot_reg] <= pts_pkg::TS_READY;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                S_PICK_WR:
                begin
                    if (finish)
                    begin
                        // Return running tasks to ready, then mark the pick waiting
                        for (int i = 0; i < TABLE_SLOTS; i++)
                        begin
                            if (active_reg[i] && (tstate_reg[i] == pts_pkg::TS_RUNNING))
                            begin
                                tstate_reg[i] <= pts_pkg::TS_READY;
                            end
                        end
                        tstate_reg[pick_slot] <= pts_pkg::TS_WAITING;
                        last_pick_reg         <= pick_slot;
                        time_reg              <= time_reg + {16'd0, interval_reg};
                        state_reg             <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Result register: load on finish, clear when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            status_reg      <= ld_status;
            result_id_reg   <= ld_id;
            result_slot_reg <= ld_slot_ext[3:0];
            tick_time_reg   <= ld_time;
            run_total_reg   <= ld_runs;
        end
    end

`ifndef NO_ASSERTIONS
    // Slot processing only happens during a scan or the post state that follows it
    a_proc_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        proc_vld_reg |-> (state_reg == S_SCAN) || (state_reg == S_POST))
        else $error("slot processed outside scan");

    // An accepted tick starts a table scan
    a_tick_scans: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && (action == pts_pkg::ACT_TICK)) |=> (state_reg == S_SCAN))
        else $error("tick did not start a scan");

    // The pick write stage only runs with a valid pick
    a_pick_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PICK_WR) |-> pick_vld)
        else $error("pick stage without a ready task");

    // A finished transaction never overwrites a result still stalled
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        finish |-> (!out_valid_reg || !out_stall))
        else $error("result overwritten while stalled");
`endif

endmodule

// ===== rtl/pts_slot_eval.sv =====
// Per-slot release check and id match for the scheduler scan.
module pts_slot_eval
(
    input  pts_pkg::entry_t     entry,
    input  logic                active,
    input  logic [1:0]          state,
    input  logic [31:0]         cur_time,
    input  logic [31:0]         target,
    output pts_pkg::slot_eval_t ev
);

    logic due;

    // Check release time and target id for one slot
    always_comb
    begin
        due            = active && (state != pts_pkg::TS_SUSPENDED)
                         && (cur_time >= entry.release_time);
        ev.release_due = due;
        ev.new_release = cur_time + {16'd0, entry.period};
        ev.ready       = active && (due || (state == pts_pkg::TS_READY));
        ev.id_match    = active && (entry.id == target);
        ev.susp_match  = active && (entry.id == target)
                         && (state == pts_pkg::TS_SUSPENDED);
    end

endmodule

// ===== verif/pts_checker.sv =====
// Checker for the periodic task scheduler: predicts each result and compares.
`timescale 1ns / 1ps
module pts_checker
    import pts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [2:0]  action,
    input  logic [7:0]  task_priority,
    input  logic [15:0] task_period,
    input  logic [31:0] target_id,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [1:0]  status,
    input  logic [31:0] result_id,
    input  logic [3:0]  result_slot,
    input  logic [31:0] tick_time,
    input  logic [31:0] run_total,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    output int          fail_count,
    output int          pending
);
    localparam int SLOTS = 16;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] rid;
        logic [3:0]  slot;
        logic [31:0] ttime;
        logic [31:0] runs;
    } sched_result_t;

    sched_result_t expected_q[$];

    logic [15:0] interval;
    logic        prio_mode;
    logic        act[SLOTS];
    logic [1:0]  tstate[SLOTS];
    logic [7:0]  prio[SLOTS];
    logic [31:0] tid[SLOTS];
    logic [15:0] period[SLOTS];
    logic [31:0] release_at[SLOTS];
    logic [31:0] runs[SLOTS];
    logic [3:0]  last_slot;
    logic [31:0] now_ms;
    logic [31:0] id_counter;

    // Count and report one mismatch
    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    // Compute the result of one transaction and advance the task table
    function automatic sched_result_t schedule_step(input logic [2:0] a, input logic [7:0] pr,
                                                    input logic [15:0] per,
                                                    input logic [31:0] tgt);
        sched_result_t r;
        int p;
        int k;
        int s;
        r = '0;
        p = -1;
        if (a == ACT_TICK) begin
            r.ttime = now_ms;
            for (int i = 0; i < SLOTS; i++)
                if (act[i] && tstate[i] != TS_SUSPENDED && now_ms >= release_at[i]) begin
                    tstate[i] = TS_READY;
                    release_at[i] = now_ms + 32'(period[i]);
                end
            if (!prio_mode) begin
                s = (int'(last_slot) + 1) % SLOTS;
                for (k = 0; k < SLOTS; k++) begin
                    if (p < 0 && act[s] && tstate[s] == TS_READY)
                        p = s;
                    s = (s + 1) % SLOTS;
                end
            end else begin
                for (int i = 0; i < SLOTS; i++)
                    if (act[i] && tstate[i] == TS_READY)
                        if (p < 0 || prio[i] < prio[p] ||
                            (prio[i] == prio[p] && tid[i] < tid[p]))
                            p = i;
            end
            if (p >= 0) begin
                for (int i = 0; i < SLOTS; i++)
                    if (act[i] && tstate[i] == TS_RUNNING)
                        tstate[i] = TS_READY;
                last_slot = 4'(p);
                runs[p] = runs[p] + 32'd1;
                tstate[p] = TS_WAITING;
                r.rid = tid[p];
                r.slot = 4'(p);
                r.runs = runs[p];
            end else begin
                r.status = STAT_IDLE;
            end
            now_ms = now_ms + 32'(interval);
        end else if (a == ACT_ADD) begin
            r.status = STAT_FULL;
            for (int i = 0; i < SLOTS; i++)
                if (r.status == STAT_FULL && !act[i]) begin
                    act[i] = 1'b1;
                    tid[i] = id_counter;
                    id_counter = id_counter + 32'd1;
                    prio[i] = pr;
                    tstate[i] = TS_READY;
                    period[i] = per;
                    release_at[i] = '0;
                    runs[i] = '0;
                    r.status = STAT_OK;
                    r.rid = tid[i];
                    r.slot = 4'(i);
                end
        end else if (a == ACT_REMOVE || a == ACT_SUSPEND) begin
            for (int i = SLOTS - 1; i >= 0; i--)
                if (act[i] && tid[i] == tgt)
                    p = i;
            if (p < 0)
                r.status = STAT_NOT_FOUND;
            else if (a == ACT_REMOVE)
                act[p] = 1'b0;
            else
                tstate[p] = TS_SUSPENDED;
        end else if (a == ACT_RESUME) begin
            r.status = STAT_NOT_FOUND;
            for (int i = 0; i < SLOTS; i++)
                if (r.status == STAT_NOT_FOUND && act[i] && tid[i] == tgt &&
                    tstate[i] == TS_SUSPENDED) begin
                    tstate[i] = TS_READY;
                    r.status = STAT_OK;
                end
        end
        return r;
    endfunction

    // Watch all three channels
    always @(posedge clk or negedge rst_n) begin
        sched_result_t want;
        if (!rst_n) begin
            interval = 16'd10;
            prio_mode = 1'b0;
            for (int i = 0; i < SLOTS; i++) begin
                act[i] = 1'b0;
                tstate[i] = TS_READY;
            end
            last_slot = 4'(SLOTS - 1);
            now_ms = '0;
            id_counter = 32'd1;
            fail_count = 0;
            expected_q.delete();
            pending = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_TICK_INTERVAL)
                    interval = cfg_data;
                else
                    prio_mode = cfg_data[0];
            end
            if (in_valid && !in_stall)
                expected_q.push_back(schedule_step(action, task_priority, task_period,
                                                   target_id));
            if (out_valid && !out_stall) begin
                if (expected_q.size() == 0) begin
                    report("unexpected transaction", 32'(status), 32'd0);
                end else begin
                    want = expected_q.pop_front();
                    if (status !== want.status) report("status", 32'(status), 32'(want.status));
                    if (result_id !== want.rid) report("result_id", result_id, want.rid);
                    if (result_slot !== want.slot)
                        report("result_slot", 32'(result_slot), 32'(want.slot));
                    if (tick_time !== want.ttime) report("tick_time", tick_time, want.ttime);
                    if (run_total !== want.runs) report("run_total", run_total, want.runs);
                end
            end
            pending = expected_q.size();
        end
    end
endmodule

// ===== verif/tb_periodic_task_scheduler.sv =====
// Testbench top for the periodic task scheduler: stimulus, idling and verdict.
`timescale 1ns / 1ps
module tb_periodic_task_scheduler;
    import pts_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [2:0]  action = '0;
    logic [7:0]  task_priority = '0;
    logic [15:0] task_period = '0;
    logic [31:0] target_id = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  status;
    logic [31:0] result_id;
    logic [3:0]  result_slot;
    logic [31:0] tick_time;
    logic [31:0] run_total;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = 1'b0;
    logic [15:0] cfg_data = '0;
    int          fail_count;
    int          pending;
    bit          quiet_phase = 1'b0;
    logic [31:0] ids_issued = 32'd1;

    always #4 clk = ~clk;

    periodic_task_scheduler uut (.*);

    pts_checker chk (.*);

    // Stall the result channel in random bursts
    initial begin
        int n;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (!quiet_phase && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 9);
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Send one transaction, with an optional idle burst first
    task automatic send_op(input logic [2:0] a, input logic [7:0] pr, input logic [15:0] per,
                           input logic [31:0] tgt);
        if (!quiet_phase && $urandom_range(0, 6) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= a;
        task_priority <= pr;
        task_period <= per;
        target_id <= tgt;
        do @(posedge clk); while (in_stall);
        if (a == ACT_ADD) ids_issued = ids_issued + 32'd1;
    endtask

    // Hold off until all results are in and the block has settled
    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // Write one configuration register
    task automatic write_cfg(input logic idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Pick a target id near recently issued ones, sometimes anything
    function automatic logic [31:0] some_id();
        if ($urandom_range(0, 9) == 0) return $urandom();
        return ids_issued - 32'($urandom_range(0, 20));
    endfunction

    // Random transaction mix, mostly ticks and adds
    task automatic random_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            send_op(ACT_TICK, 8'($urandom()), 16'($urandom()), $urandom());
        else if (r < 65)
            send_op(ACT_ADD, 8'($urandom()), ($urandom_range(0, 3) == 0) ? 16'($urandom())
                    : 16'($urandom_range(0, 60)), $urandom());
        else if (r < 77)
            send_op(ACT_REMOVE, 8'($urandom()), 16'($urandom()), some_id());
        else if (r < 87)
            send_op(ACT_SUSPEND, 8'($urandom()), 16'($urandom()), some_id());
        else if (r < 97)
            send_op(ACT_RESUME, 8'($urandom()), 16'($urandom()), some_id());
        else
            send_op(3'($urandom_range(5, 7)), 8'($urandom()), 16'($urandom()), $urandom());
    endtask

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: idle tick, extremes, fill table, overflow, unknown actions
        send_op(ACT_TICK, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF);
        send_op(ACT_ADD, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF);
        send_op(ACT_ADD, 8'h00, 16'h0000, 32'h0);
        send_op(ACT_TICK, 8'd0, 16'd0, 32'd0);
        send_op(ACT_SUSPEND, 8'd0, 16'd0, 32'd1);
        send_op(ACT_RESUME, 8'd0, 16'd0, 32'd1);
        send_op(ACT_RESUME, 8'd0, 16'd0, 32'd1);
        send_op(ACT_REMOVE, 8'd0, 16'd0, 32'hFFFF_FFFF);
        for (int i = 0; i < 15; i++)
            send_op(ACT_ADD, 8'(i % 3), 16'(i * 7), 32'd0);
        send_op(3'd5, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF);
        send_op(3'd7, 8'd0, 16'd0, 32'd0);
        drain();

        write_cfg(CFG_POLICY_MODE, 16'd1);
        write_cfg(CFG_TICK_INTERVAL, 16'hFFFF);
        for (int i = 0; i < 400; i++) random_op();
        drain();

        write_cfg(CFG_TICK_INTERVAL, 16'd1);
        write_cfg(CFG_POLICY_MODE, 16'd0);
        for (int i = 0; i < 500; i++) random_op();
        drain();

        write_cfg(CFG_POLICY_MODE, 16'd1);
        write_cfg(CFG_TICK_INTERVAL, 16'($urandom_range(1, 30)));
        for (int i = 0; i < 500; i++) random_op();
        drain();

        // Final stretch without idling
        write_cfg(CFG_POLICY_MODE, 16'd0);
        write_cfg(CFG_TICK_INTERVAL, 16'd10);
        quiet_phase = 1'b1;
        for (int i = 0; i < 500; i++) random_op();
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (40) @(posedge clk);

        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Timeout
    initial begin
        #8_000_000;
        $display("CHECK FAILED");
        $finish;
    end
endmodule
